/* rtl/core/owm_pkg.sv */
// Shared types, constants and the CRC-8 helper for the 1-Wire bus master.
package owm_pkg;

  localparam int unsigned TickW = 10;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegIdxW = $clog2(NumRegs);

  // Start codes carried with each tick
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Operation phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_TAIL = 3'd3,
    PH_WR_SLOT  = 3'd4,
    PH_RD_SLOT  = 3'd5
  } phase_e;

  // Configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_RESET_LOW      = 3'd0,
    REG_PRESENCE_SAMPLE = 3'd1,
    REG_RESET_TAIL     = 3'd2,
    REG_WRITE_ONE_LOW  = 3'd3,
    REG_WRITE_ZERO_LOW = 3'd4,
    REG_SLOT           = 3'd5,
    REG_READ_LOW       = 3'd6,
    REG_READ_SAMPLE    = 3'd7
  } reg_idx_e;

  localparam logic [TickW-1:0] RESET_LOW_DEF       = 10'd480;
  localparam logic [TickW-1:0] PRESENCE_SAMPLE_DEF = 10'd70;
  localparam logic [TickW-1:0] RESET_TAIL_DEF      = 10'd410;
  localparam logic [TickW-1:0] WRITE_ONE_LOW_DEF   = 10'd6;
  localparam logic [TickW-1:0] WRITE_ZERO_LOW_DEF  = 10'd60;
  localparam logic [TickW-1:0] SLOT_DEF            = 10'd70;
  localparam logic [TickW-1:0] READ_LOW_DEF        = 10'd6;
  localparam logic [TickW-1:0] READ_SAMPLE_DEF     = 10'd9;

  // Reflected polynomial of x^8+x^5+x^4+1
  localparam logic [7:0] CRC8_POLY = 8'h8C;

  typedef struct packed {
    logic [TickW-1:0] reset_low;
    logic [TickW-1:0] presence_sample;
    logic [TickW-1:0] reset_tail;
    logic [TickW-1:0] write_one_low;
    logic [TickW-1:0] write_zero_low;
    logic [TickW-1:0] slot;
    logic [TickW-1:0] read_low;
    logic [TickW-1:0] read_sample;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] write_data;
    logic       line_level;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       no_presence;
    logic [7:0] crc_value;
    logic       cmd_rejected;
  } res_t;

  // Fold one byte into the Dallas CRC-8, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* rtl/core/owm_if.sv */
// Valid/ready channel interfaces for the 1-Wire bus master items and results.
interface owm_in_if;
  import owm_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] write_data;
  logic       line_level;

  modport source (output valid, cmd, write_data, line_level, input ready);
  modport sink (input valid, cmd, write_data, line_level, output ready);
endinterface

interface owm_out_if;
  import owm_pkg::*;
  logic       valid;
  logic       ready;
  logic       drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_byte;
  logic       no_presence;
  logic [7:0] crc_value;
  logic       cmd_rejected;

  modport source (output valid, drive_low, busy_res, done_res, read_byte, no_presence,
                  crc_value, cmd_rejected, input ready);
  modport sink (input valid, drive_low, busy_res, done_res, read_byte, no_presence,
                crc_value, cmd_rejected, output ready);
endinterface

/* rtl/core/owm_cfg_regs.sv */
// Timing configuration registers of the 1-Wire bus master.
module owm_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [owm_pkg::RegIdxW-1:0]   cfg_idx_i,
  input  logic [owm_pkg::TickW-1:0]     cfg_wdata_i,
  output owm_pkg::cfg_t                 cfg_o
);
  import owm_pkg::*;

  cfg_t cfg_q;

  // Write the addressed register, defaults at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low       <= RESET_LOW_DEF;
      cfg_q.presence_sample <= PRESENCE_SAMPLE_DEF;
      cfg_q.reset_tail      <= RESET_TAIL_DEF;
      cfg_q.write_one_low   <= WRITE_ONE_LOW_DEF;
      cfg_q.write_zero_low  <= WRITE_ZERO_LOW_DEF;
      cfg_q.slot            <= SLOT_DEF;
      cfg_q.read_low        <= READ_LOW_DEF;
      cfg_q.read_sample     <= READ_SAMPLE_DEF;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RESET_LOW:       cfg_q.reset_low       <= cfg_wdata_i;
        REG_PRESENCE_SAMPLE: cfg_q.presence_sample <= cfg_wdata_i;
        REG_RESET_TAIL:      cfg_q.reset_tail      <= cfg_wdata_i;
        REG_WRITE_ONE_LOW:   cfg_q.write_one_low   <= cfg_wdata_i;
        REG_WRITE_ZERO_LOW:  cfg_q.write_zero_low  <= cfg_wdata_i;
        REG_SLOT:            cfg_q.slot            <= cfg_wdata_i;
        REG_READ_LOW:        cfg_q.read_low        <= cfg_wdata_i;
        REG_READ_SAMPLE:     cfg_q.read_sample     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/owm_engine.sv */
// Bus timing state machine: advances one tick per step and forms the result.
module owm_engine (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  owm_pkg::item_t item_i,
  input  owm_pkg::cfg_t  cfg_i,
  output owm_pkg::res_t  res_o
);
  import owm_pkg::*;

  phase_e             phase_q, phase_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic [2:0]         bit_q, bit_d;
  logic [7:0]         shift_q, shift_d;
  logic [7:0]         crc_q, crc_d;
  logic               pres_q, pres_d;
  logic [7:0]         last_q, last_d;

  logic [TickW-1:0]   tick_inc;
  logic [TickW-1:0]   slot_end;
  logic [TickW-1:0]   low_time;
  logic [TickW:0]     sample_sum;
  logic [TickW:0]     sample_pt;
  logic               slot_last;
  logic               drive;
  logic               done;
  logic               rejected;

  // Next state for one tick, with an optional start command
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    crc_d    = crc_q;
    pres_d   = pres_q;
    last_d   = last_q;
    drive    = 1'b0;
    done     = 1'b0;
    rejected = 1'b0;

    // Take a start command only when idle
    if (cmd_e'(item_i.cmd) != CMD_TICK) begin
      if (phase_q != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        tick_d = '0;
        bit_d  = '0;
        case (cmd_e'(item_i.cmd))
          CMD_RESET: begin
            phase_d = PH_RST_LOW;
            crc_d   = '0;
          end
          CMD_WRITE: begin
            phase_d = PH_WR_SLOT;
            shift_d = item_i.write_data;
          end
          CMD_READ: begin
            phase_d = PH_RD_SLOT;
            shift_d = '0;
          end
          default: ;
        endcase
      end
    end

    slot_end   = (cfg_i.slot == '0) ? TickW'(1) : cfg_i.slot;
    tick_inc   = tick_d + TickW'(1);
    slot_last  = (tick_inc >= slot_end);
    low_time   = shift_d[0] ? cfg_i.write_one_low : cfg_i.write_zero_low;
    sample_sum = {1'b0, cfg_i.read_low} + {1'b0, cfg_i.read_sample};
    sample_pt  = (sample_sum > {1'b0, slot_end}) ? {1'b0, slot_end} : sample_sum;
    if (sample_pt == '0) begin
      sample_pt = (TickW+1)'(1);
    end

    // Advance the running operation by one tick
    case (phase_d)
      PH_IDLE: ;
      PH_RST_LOW: begin
        drive  = 1'b1;
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.reset_low) begin
          phase_d = PH_RST_WAIT;
          tick_d  = '0;
        end
      end
      PH_RST_WAIT: begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.presence_sample) begin
          pres_d  = item_i.line_level;
          phase_d = PH_RST_TAIL;
          tick_d  = '0;
        end
      end
      PH_RST_TAIL: begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.reset_tail) begin
          phase_d = PH_IDLE;
          tick_d  = '0;
          done    = 1'b1;
        end
      end
      PH_WR_SLOT: begin
        drive  = (tick_inc <= low_time);
        tick_d = tick_inc;
        if (slot_last) begin
          tick_d  = '0;
          shift_d = shift_d >> 1;
          bit_d   = bit_d + 3'd1;
          if (bit_d == '0) begin
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
      end
      PH_RD_SLOT: begin
        drive  = (tick_inc <= cfg_i.read_low);
        tick_d = tick_inc;
        if ({1'b0, tick_inc} == sample_pt) begin
          shift_d = {item_i.line_level, shift_d[7:1]};
        end
        if (slot_last) begin
          tick_d = '0;
          bit_d  = bit_d + 3'd1;
          if (bit_d == '0) begin
            last_d  = shift_d;
            crc_d   = crc8_byte(crc_d, shift_d);
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  // Commit the state on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      crc_q   <= '0;
      pres_q  <= 1'b0;
      last_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      crc_q   <= crc_d;
      pres_q  <= pres_d;
      last_q  <= last_d;
    end
  end

  assign res_o.drive_low    = drive;
  assign res_o.busy_res     = (phase_d != PH_IDLE);
  assign res_o.done_res     = done;
  assign res_o.read_byte    = last_d;
  assign res_o.no_presence  = pres_d;
  assign res_o.crc_value    = crc_d;
  assign res_o.cmd_rejected = rejected;

endmodule

/* rtl/core/one_wire_bus_master_top.sv */
// 1-Wire bus master timed by microsecond ticks: input register, engine, result register.
//
// Usage:
//   Send one item per microsecond on in_i. cmd selects a plain tick or starts
//   a bus reset, a byte write (write_data) or a byte read; line_level is the
//   sampled bus level for that tick. Every item yields exactly one result on
//   out_o: drive_low for the open-drain driver, busy and done flags, the last
//   byte read, the presence flag, the running CRC-8 and a reject flag for a
//   start command that arrived while an operation was running.
//   Timing registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i and
//   take effect on the next item; write them only while the master is idle.
// Pipeline and throughput:
//   An item is held in the input register and its result in the result
//   register, from which it is offered on out_o. One item per cycle is
//   sustained while out_o is not held.
// Reset:
//   rst_ni clears both pipeline registers, returns the engine to idle with
//   CRC, presence flag and read byte at zero, and loads the default timings.
// Stall:
//   While out_o is held, a pending result waits in the result register and one
//   further item is still taken into the input register; then in_i.ready drops.
module one_wire_bus_master_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  owm_in_if.sink                      in_i,
  owm_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [owm_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [owm_pkg::TickW-1:0]   cfg_wdata_i
);
  import owm_pkg::*;

  cfg_t  cfg;
  item_t item_q;
  logic  in_vld_q;
  res_t  res;
  res_t  res_q;
  logic  out_vld_q;
  logic  advance;
  logic  step;

  owm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign advance    = !out_vld_q || out_o.ready;
  assign step       = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  // Input register: load on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.cmd        <= in_i.cmd;
      item_q.write_data <= in_i.write_data;
      item_q.line_level <= in_i.line_level;
    end
  end

  owm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.drive_low    = res_q.drive_low;
  assign out_o.busy_res     = res_q.busy_res;
  assign out_o.done_res     = res_q.done_res;
  assign out_o.read_byte    = res_q.read_byte;
  assign out_o.no_presence  = res_q.no_presence;
  assign out_o.crc_value    = res_q.crc_value;
  assign out_o.cmd_rejected = res_q.cmd_rejected;

endmodule

/* rtl/core/owm_checker.sv */
// Port-level checks for the 1-Wire bus master, bound to the top level.
module owm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       busy_i,
  input logic       done_i,
  input logic [7:0] crc_i
);

  // A completing operation leaves the master idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && done_i |-> !busy_i)
    else $error("done result still reports busy");

  // An empty result register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with no pending result");

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("stalled result dropped");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(busy_i) && $stable(done_i) && $stable(crc_i))
    else $error("stalled result changed");

endmodule

bind one_wire_bus_master_top owm_checker u_owm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .busy_i      (out_o.busy_res),
  .done_i      (out_o.done_res),
  .crc_i       (out_o.crc_value)
);
